@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
// Depends on nothing; each macro compiles away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication or sequence property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/core/lpd_pkg.sv @@
// Shared types and constants for the length-prefix deframer.
// Used by lpd_front, lpd_fifo, lpd_back and length_prefix_deframer.
package lpd_pkg;

    localparam int LPD_CONNS     = 16;
    localparam int LPD_CONN_W    = 4;
    localparam int LPD_LEN_W     = 24;
    localparam int LPD_QDEPTH    = 4;
    localparam int LPD_QPTR_W    = $clog2(LPD_QDEPTH);
    localparam int LPD_QCNT_W    = $clog2(LPD_QDEPTH + 1);
    localparam int LPD_IN_W      = 16;
    localparam int LPD_OUT_W     = 48;

    localparam logic [1:0]           LPD_HDR_LAST  = 2'd3;
    localparam logic [LPD_LEN_W-1:0] LPD_MAX_RESET = 24'd10485760;

    // Register index decoded from paddr
    localparam logic REG_MAX_BODY_LEN = 1'b0;

    typedef enum logic {
        ACT_DATA  = 1'b0,
        ACT_CLEAR = 1'b1
    } t_action;

    typedef enum logic {
        KIND_BODY  = 1'b0,
        KIND_ERROR = 1'b1
    } t_kind;

    typedef struct packed {
        logic [LPD_CONN_W-1:0] conn;
        t_kind                 kind;
        logic [7:0]            body_byte;
        logic                  last;
        logic [31:0]           bad_length;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/core/lpd_front.sv @@
// Front end: accepts input transactions and updates the per-connection context.
// Depends on lpd_pkg; pushes body bytes and length errors into the result queue.
module lpd_front
    import lpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [LPD_IN_W-1:0]  i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic [LPD_LEN_W-1:0] i_max_len,
    input  t_q_stat              i_q_stat,
    output logic                 o_push,
    output t_result              o_res
);

    logic [1:0]           r_cnt [LPD_CONNS];
    logic [LPD_LEN_W-1:0] r_hdr [LPD_CONNS];
    logic [LPD_LEN_W-1:0] r_rem [LPD_CONNS];

    logic [1:0]           n_cnt;
    logic [LPD_LEN_W-1:0] n_hdr;
    logic [LPD_LEN_W-1:0] n_rem;

    logic [LPD_CONN_W-1:0] conn;
    logic [7:0]            data_byte;
    t_action               action;
    logic                  accept;
    logic                  in_range;
    logic [31:0]           len;
    logic                  len_ok;

    assign conn       = i_s_tdata[LPD_CONN_W-1:0];
    assign data_byte  = i_s_tdata[LPD_CONN_W+7:LPD_CONN_W];
    assign action     = t_action'(i_s_tuser);
    assign o_s_tready = !i_q_stat.full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_range   = (int'(conn) < LPD_CONNS);

    assign len    = {r_hdr[conn], data_byte};
    assign len_ok = (len != 32'd0) && (len[31:LPD_LEN_W] == '0)
                    && (len[LPD_LEN_W-1:0] <= i_max_len);

    always_comb begin
        n_cnt            = r_cnt[conn];
        n_hdr            = r_hdr[conn];
        n_rem            = r_rem[conn];
        o_push           = 1'b0;
        o_res.conn       = conn;
        o_res.kind       = KIND_BODY;
        o_res.body_byte  = data_byte;
        o_res.last       = (r_rem[conn] == LPD_LEN_W'(1));
        o_res.bad_length = '0;
        if (action == ACT_CLEAR) begin
            n_cnt = '0;
            n_hdr = '0;
            n_rem = '0;
        end else if (r_rem[conn] != '0) begin
            n_rem  = r_rem[conn] - LPD_LEN_W'(1);
            o_push = accept && in_range;
        end else if (r_cnt[conn] != LPD_HDR_LAST) begin
            n_hdr = {r_hdr[conn][LPD_LEN_W-9:0], data_byte};
            n_cnt = r_cnt[conn] + 2'd1;
        end else begin
            n_cnt = '0;
            n_hdr = '0;
            if (len_ok) begin
                n_rem = len[LPD_LEN_W-1:0];
            end else begin
                // report the rejected length, restart at a header
                o_res.kind       = KIND_ERROR;
                o_res.body_byte  = '0;
                o_res.last       = 1'b0;
                o_res.bad_length = len;
                o_push           = accept && in_range;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LPD_CONNS; i++) begin
                r_cnt[i] <= '0;
                r_hdr[i] <= '0;
                r_rem[i] <= '0;
            end
        end else if (accept && in_range) begin
            r_cnt[conn] <= n_cnt;
            r_hdr[conn] <= n_hdr;
            r_rem[conn] <= n_rem;
        end
    end

endmodule

@@ rtl/core/lpd_fifo.sv @@
// Short result queue between the deframer front end and the output stage.
// Depends on lpd_pkg for the result type and depth.
module lpd_fifo
    import lpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output t_result o_data,
    output t_q_stat o_stat
);

    t_result               r_mem [LPD_QDEPTH];
    logic [LPD_QPTR_W-1:0] r_wr_ptr;
    logic [LPD_QPTR_W-1:0] r_rd_ptr;
    logic [LPD_QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == LPD_QCNT_W'(LPD_QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + LPD_QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + LPD_QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + LPD_QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - LPD_QCNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/lpd_back.sv @@
// Back end: drains the result queue into the registered output stream.
// Depends on lpd_pkg for the result type and stream widths.
module lpd_back
    import lpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_stat               i_q_stat,
    input  t_result               i_res,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [LPD_OUT_W-1:0]  o_m_tdata,
    output logic                  o_m_tuser,
    output logic                  o_m_tlast
);

    logic    r_valid;
    t_result r_res;

    // refill the output register whenever it is empty or being taken
    assign o_pop = !i_q_stat.empty && (!r_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {4'b0, r_res.bad_length, r_res.body_byte, r_res.conn};
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.last;

endmodule

@@ rtl/core/length_prefix_deframer.sv @@
// Top level of the length-prefix deframer: config register, front end, queue, back end.
// Depends on lpd_pkg, assert_macros.svh, lpd_front, lpd_fifo and lpd_back.
//
//  channel   | direction | handshake                 | contents
//  ----------+-----------+---------------------------+---------------------------------
//  s stream  | in        | i_s_tvalid / o_s_tready   | action, conn, data_byte
//  m stream  | out       | o_m_tvalid / i_m_tready   | conn_out, kind, body_byte, last,
//            |           |                           | bad_length
//  APB       | in/out    | psel, penable, pready     | max_body_len at byte address 0
//
// One input transaction per cycle; the context update of a connection completes in
// the accept cycle, so back-to-back bytes of the same connection need no wait.
// A result is registered in a result queue entry and then in the output register before it leaves.
// Input stalls only when the four-entry result queue is full.
// Synchronous active-low reset clears all sixteen contexts at once and sets
// max_body_len to 10485760.
`include "assert_macros.svh"
module length_prefix_deframer
    import lpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [LPD_IN_W-1:0]  i_s_tdata,   // [3:0] conn, [11:4] data_byte, [15:12] zero
    input  logic                 i_s_tuser,   // [0] action
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [LPD_OUT_W-1:0] o_m_tdata,   // [3:0] conn_out, [11:4] body_byte,
                                              // [43:12] bad_length, [47:44] zero
    output logic                 o_m_tuser,   // [0] kind
    output logic                 o_m_tlast,   // last
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [LPD_LEN_W-1:0] r_max_len;
    logic                 reg_sel;

    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;
    t_result front_res;
    t_result q_res;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign prdata  = (reg_sel == REG_MAX_BODY_LEN) ? {8'b0, r_max_len} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= LPD_MAX_RESET;
        end else if (psel && penable && pwrite && pready
                     && (reg_sel == REG_MAX_BODY_LEN)) begin
            r_max_len <= pwdata[LPD_LEN_W-1:0];
        end
    end

    lpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_max_len  (r_max_len),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_res      (front_res)
    );

    lpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_res),
        .i_pop   (q_pop),
        .o_data  (q_res),
        .o_stat  (q_stat)
    );

    lpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_res      (q_res),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, q_push && q_stat.full, "push into full queue")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, q_pop && q_stat.empty, "pop from empty queue")
    `ASSERT_PROP(a_refill, i_clk, i_rst_n, (!q_stat.empty && !o_m_tvalid) |=> o_m_tvalid, "output not refilled from queue")
    `ASSERT_PROP(a_err_fields, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser) |-> (!o_m_tlast && o_m_tdata[11:4] == 8'd0), "error result with body fields set")

endmodule

@@ test/tb.sv @@
// Self-checking bench for length_prefix_deframer: stream driver, result monitor and APB tasks.
// Predicts each result from a per-connection context model; depends on lpd_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
    import lpd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        t_action    act;
        logic [3:0] conn;
        logic [7:0] data;
    } t_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [LPD_IN_W-1:0]  s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [LPD_OUT_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    t_item   cur_item = '0;
    t_item   pending_q[$];
    t_result expected_q[$];
    int      errors = 0;
    int      cycles = 0;

    // deframer context as the bench sees it
    logic [2:0]  hdr_cnt  [LPD_CONNS];
    logic [23:0] hdr_acc  [LPD_CONNS];
    logic [23:0] body_left[LPD_CONNS];
    logic [23:0] max_len;

    // sender and receiver pacing
    logic calm = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   rx_tick = 0;
    int   rx_period = 1;
    int   rx_low = 0;

    // stimulus generator state per connection
    int          gen_pos [LPD_CONNS];
    int          gen_body[LPD_CONNS];
    logic [31:0] gen_len [LPD_CONNS];

    assign s_tdata = {4'd0, cur_item.data, cur_item.conn};
    assign s_tuser = cur_item.act;

    length_prefix_deframer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic deframe_step(input t_item it, output t_result r);
        logic [31:0] len;
        r = '0;
        r.conn = it.conn;
        r.kind = KIND_BODY;
        if (it.act == ACT_CLEAR) begin
            hdr_cnt[it.conn] = '0;
            hdr_acc[it.conn] = '0;
            body_left[it.conn] = '0;
            return 1'b0;
        end
        if (body_left[it.conn] != 0) begin
            r.body_byte = it.data;
            r.last = (body_left[it.conn] == 24'd1);
            body_left[it.conn] = body_left[it.conn] - 24'd1;
            return 1'b1;
        end
        if (hdr_cnt[it.conn] < 3'd3) begin
            hdr_acc[it.conn] = {hdr_acc[it.conn][15:0], it.data};
            hdr_cnt[it.conn] = hdr_cnt[it.conn] + 3'd1;
            return 1'b0;
        end
        // fourth header byte completes the length
        len = {hdr_acc[it.conn], it.data};
        hdr_cnt[it.conn] = '0;
        hdr_acc[it.conn] = '0;
        if (len != 0 && !len[31] && len <= {8'd0, max_len}) begin
            body_left[it.conn] = len[23:0];
            return 1'b0;
        end
        r.kind = KIND_ERROR;
        r.bad_length = len;
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // driver: bursts of transactions with random gaps between them
    always @(posedge i_clk) begin : drive
        t_item   nxt;
        logic    nv;
        t_result res;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            nv = s_tvalid;
            nxt = cur_item;
            if (s_tvalid && s_tready) begin
                if (deframe_step(cur_item, res))
                    expected_q.push_back(res);
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    nxt = pending_q.pop_front();
                    nv = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = calm ? 0 : $urandom_range(0, 6);
                    end
                end
            end
            s_tvalid <= nv;
            cur_item <= nxt;
        end
    end

    // monitor: compare each result transaction, then pace tready
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, conn %0d kind %0d tdata %0h",
                             $time, m_tdata[3:0], m_tuser, m_tdata);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("conn_out", 32'(want.conn), 32'(m_tdata[3:0]));
                    check_field("kind", 32'(want.kind), 32'(m_tuser));
                    check_field("body_byte", 32'(want.body_byte), 32'(m_tdata[11:4]));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                    check_field("bad_length", want.bad_length, m_tdata[43:12]);
                end
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                rx_tick++;
                if (rx_tick >= rx_period) begin
                    rx_tick = 0;
                    rx_period = $urandom_range(1, 24);
                    rx_low = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_period - 1);
                end
                m_tready <= (rx_tick >= rx_low);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_data(input logic [3:0] c, input logic [7:0] b);
        pending_q.push_back('{act: ACT_DATA, conn: c, data: b});
    endtask

    task automatic push_clear(input logic [3:0] c);
        pending_q.push_back('{act: ACT_CLEAR, conn: c, data: 8'($urandom)});
    endtask

    task automatic push_header(input logic [3:0] c, input logic [31:0] len);
        push_data(c, len[31:24]);
        push_data(c, len[23:16]);
        push_data(c, len[15:8]);
        push_data(c, len[7:0]);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[2] == REG_MAX_BODY_LEN)
            max_len = val[23:0];
    endtask

    task automatic reg_read_check(input logic [2:0] addr);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("prdata", {8'd0, max_len}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until the block has taken everything and returned every result
    task automatic drain;
        do @(posedge i_clk);
        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic gen_random(input int n);
        int          k;
        int          r;
        int          lim;
        logic [3:0]  c;
        logic [31:0] len;
        for (k = 0; k < n; k++) begin
            c = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                push_clear(c);
                gen_pos[c] = 0;
                gen_body[c] = 0;
            end else if (r < 6) begin
                push_data(c, 8'($urandom));
            end else begin
                if (gen_pos[c] == 0) begin
                    // pick the next message on this connection
                    r = $urandom_range(0, 99);
                    gen_body[c] = 0;
                    if (r < 75 && max_len != 0) begin
                        lim = (max_len < 24) ? int'(max_len) : 24;
                        len = $urandom_range(1, lim);
                        if (max_len > 24 && $urandom_range(0, 99) < 4)
                            len = $urandom_range(25, (max_len < 300) ? int'(max_len) : 300);
                        gen_body[c] = len;
                    end else if (r < 80) begin
                        len = '0;
                    end else if (r < 87) begin
                        len = {1'b1, 31'($urandom)};
                    end else if (r < 95) begin
                        len = {8'd0, max_len} + 32'd1
                            + ($urandom % (32'h7FFF_FFFF - {8'd0, max_len}));
                    end else begin
                        len = $urandom;
                    end
                    gen_len[c] = len;
                end
                if (gen_pos[c] < 4) begin
                    push_data(c, 8'(gen_len[c] >> (8 * (3 - gen_pos[c]))));
                    gen_pos[c]++;
                    if (gen_pos[c] == 4 && gen_body[c] == 0)
                        gen_pos[c] = 0;
                end else begin
                    push_data(c, 8'($urandom));
                    gen_body[c]--;
                    if (gen_body[c] == 0)
                        gen_pos[c] = 0;
                end
            end
        end
    endtask

    initial begin : main
        logic [23:0] setting[5];
        int          p;
        for (p = 0; p < LPD_CONNS; p++) begin
            hdr_cnt[p] = '0;
            hdr_acc[p] = '0;
            body_left[p] = '0;
            gen_pos[p] = 0;
            gen_body[p] = 0;
            gen_len[p] = '0;
        end
        max_len = LPD_MAX_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset maximum: one above is rejected, exactly the maximum is taken
        reg_read_check(3'd0);
        push_header(4'd1, {8'd0, LPD_MAX_RESET} + 32'd1);
        push_header(4'd2, {8'd0, LPD_MAX_RESET});
        push_data(4'd2, 8'hFF);
        push_clear(4'd2);
        drain();

        reg_write(3'd0, 32'd2);
        reg_read_check(3'd0);
        // interleaved connections, byte extremes, bad lengths, clear inside a header
        push_header(4'd0, 32'd2);
        push_header(4'd15, 32'hFFFF_FFFF);
        push_data(4'd0, 8'h00);
        push_header(4'd6, 32'd0);
        push_data(4'd0, 8'hFF);
        push_header(4'd4, 32'h8000_0000);
        push_data(4'd7, 8'h00);
        push_clear(4'd7);
        push_header(4'd7, 32'd3);
        drain();

        // zero maximum rejects every header
        reg_write(3'd0, 32'd0);
        reg_read_check(3'd0);
        push_header(4'd9, 32'd1);
        drain();
        // write outside the register map must leave the maximum alone
        reg_write(3'd4, 32'd77);
        reg_read_check(3'd0);
        push_header(4'd10, 32'h7FFF_FFFF);
        drain();

        setting[0] = 24'hFF_FFFF;
        setting[1] = 24'd1;
        setting[2] = 24'd40;
        setting[3] = 24'($urandom_range(2, 500));
        setting[4] = 24'd6;
        for (p = 0; p < 5; p++) begin
            reg_write(3'd0, {8'd0, setting[p]});
            reg_read_check(3'd0);
            calm <= (p == 2);
            // hold the receiver off while the sender keeps offering
            if (p == 2)
                hold_req <= hold_req + 1;
            gen_random(160);
            drain();
        end

        if (errors == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
